### rtl/fba_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fba_pkg: shared definitions for the file block allocator
// Sizes, field widths, result codes and the command and status bundles that
// connect the controller and the datapath.
// ----------------------------------------------------------------------------
package fba_pkg;

    // Disk and directory sizes.
    localparam int BLOCKS  = 32;
    localparam int ENTRIES = 32;

    // Derived widths.
    localparam int BLK_W   = $clog2(BLOCKS);
    localparam int ENT_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int FREE_W  = $clog2(BLOCKS + 1);
    localparam int USED_W  = $clog2(ENTRIES + 1);
    localparam int LIST_AW = ENT_W + BLK_W;

    // Fixed field widths of the request and result words.
    localparam int NAME_W   = 8;
    localparam int CNT_W    = 6;
    localparam int STATUS_W = 3;
    localparam int OUT_W    = 5;

    // Common width for comparing a request size against the free count.
    localparam int CMP_W = (FREE_W > CNT_W) ? FREE_W : CNT_W;

    typedef logic [STATUS_W-1:0] t_status;

    // Result status codes.
    localparam t_status ST_CREATED   = t_status'(0);
    localparam t_status ST_DIR_FULL  = t_status'(1);
    localparam t_status ST_NO_SPACE  = t_status'(2);
    localparam t_status ST_DELETED   = t_status'(3);
    localparam t_status ST_NOT_FOUND = t_status'(4);

    // Request opcode for a delete; the other value is a create.
    localparam logic OP_DELETE = 1'b1;

    // One directory record besides its valid bit.
    typedef struct packed {
        logic [NAME_W-1:0] name;
        logic [CNT_W-1:0]  count;
    } t_dir_entry;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    load;
        logic    slot_next;
        logic    alloc_step;
        logic    commit_create;
        logic    name_rd;
        logic    list_rd;
        logic    commit_delete;
        logic    res_load;
        t_status res_status;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_delete;
        logic dir_full;
        logic no_space;
        logic slot_free;
        logic slot_last;
        logic alloc_done;
        logic name_match;
        logic list_more;
        logic list_pend;
        logic out_busy;
    } t_sts;

endpackage
`default_nettype wire

### rtl/fba_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fba_req_if: request channel of the file block allocator
// Carries one create or delete request word with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface fba_req_if;
    logic                        valid;
    logic                        ready;
    logic                        op;
    logic [fba_pkg::NAME_W-1:0]  file_name;
    logic [fba_pkg::CNT_W-1:0]   block_count;

    modport source (output valid, output op, output file_name, output block_count,
                    input ready);
    modport sink   (input valid, input op, input file_name, input block_count,
                    output ready);
endinterface
`default_nettype wire

### rtl/fba_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fba_rsp_if: result channel of the file block allocator
// Carries one result word (status, slot, first and last block) per request.
// ----------------------------------------------------------------------------
interface fba_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [fba_pkg::STATUS_W-1:0]  status;
    logic [fba_pkg::OUT_W-1:0]     slot;
    logic [fba_pkg::OUT_W-1:0]     first_block;
    logic [fba_pkg::OUT_W-1:0]     last_block;

    modport source (output valid, output status, output slot, output first_block,
                    output last_block, input ready);
    modport sink   (input valid, input status, input slot, input first_block,
                    input last_block, output ready);
endinterface
`default_nettype wire

### rtl/fba_dpath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fba_dpath: allocator datapath
// Holds the block bitmap, the directory valid bits, the directory and block
// list memories, the scan counters and the result register.
// ----------------------------------------------------------------------------
module fba_dpath (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_op,
    input  wire logic [fba_pkg::NAME_W-1:0]    i_file_name,
    input  wire logic [fba_pkg::CNT_W-1:0]     i_block_count,
    input  wire fba_pkg::t_cmd                 i_cmd,
    output fba_pkg::t_sts                      o_sts,
    input  wire logic                          i_out_ready,
    output logic                               o_out_valid,
    output logic [fba_pkg::STATUS_W-1:0]       o_status,
    output logic [fba_pkg::OUT_W-1:0]          o_slot,
    output logic [fba_pkg::OUT_W-1:0]          o_first_block,
    output logic [fba_pkg::OUT_W-1:0]          o_last_block
);

    // Latched request.
    logic                          r_op;
    logic [fba_pkg::NAME_W-1:0]    r_name;
    logic [fba_pkg::CNT_W-1:0]     r_want;

    // Scan counters.
    logic [fba_pkg::ENT_W-1:0]     r_slot;
    logic [fba_pkg::BLK_W-1:0]     r_blk;
    logic [fba_pkg::CNT_W-1:0]     r_got;
    logic [fba_pkg::CNT_W-1:0]     r_idx;

    // First and last block touched by the current request.
    logic [fba_pkg::BLK_W-1:0]     r_first;
    logic [fba_pkg::BLK_W-1:0]     r_last;

    // Allocation state.
    logic [fba_pkg::BLOCKS-1:0]    r_block_used;
    logic [fba_pkg::ENTRIES-1:0]   r_entry_valid;
    logic [fba_pkg::FREE_W-1:0]    r_free_cnt;
    logic [fba_pkg::USED_W-1:0]    r_used_slots;

    // Directory memory and its read register.
    fba_pkg::t_dir_entry           r_dir_mem [fba_pkg::ENTRIES];
    fba_pkg::t_dir_entry           r_dir_q;

    // Block list memory, one row of BLOCKS-aligned entries per slot.
    logic [fba_pkg::BLK_W-1:0]     r_list_mem [2**fba_pkg::LIST_AW];
    logic [fba_pkg::BLK_W-1:0]     r_lst_q;
    logic                          r_lst_pend;
    logic                          r_lst_first;

    // Result register.
    logic                          r_out_vld;
    logic [fba_pkg::STATUS_W-1:0]  r_out_status;
    logic [fba_pkg::OUT_W-1:0]     r_out_slot;
    logic [fba_pkg::OUT_W-1:0]     r_out_first;
    logic [fba_pkg::OUT_W-1:0]     r_out_last;

    logic                          w_claim;
    logic                          w_res_ok;

    // A block is claimed when the allocation scan sits on a free block.
    assign w_claim  = i_cmd.alloc_step && !r_block_used[r_blk];
    assign w_res_ok = (i_cmd.res_status == fba_pkg::ST_CREATED) ||
                      (i_cmd.res_status == fba_pkg::ST_DELETED);

    // Status toward the controller.
    always_comb begin
        o_sts.is_delete  = (r_op == fba_pkg::OP_DELETE);
        o_sts.dir_full   = (r_used_slots == fba_pkg::USED_W'(fba_pkg::ENTRIES));
        o_sts.no_space   = (fba_pkg::CMP_W'(r_want) > fba_pkg::CMP_W'(r_free_cnt));
        o_sts.slot_free  = !r_entry_valid[r_slot];
        o_sts.slot_last  = (r_slot == fba_pkg::ENT_W'(fba_pkg::ENTRIES - 1));
        o_sts.alloc_done = (r_got == r_want);
        o_sts.name_match = (r_dir_q.name == r_name);
        o_sts.list_more  = (r_idx < r_dir_q.count);
        o_sts.list_pend  = r_lst_pend;
        o_sts.out_busy   = r_out_vld && !i_out_ready;
    end

    // Request latch and scan counters.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_op;
            r_name  <= i_file_name;
            r_want  <= i_block_count;
            r_slot  <= '0;
            r_blk   <= '0;
            r_got   <= '0;
            r_idx   <= '0;
            r_first <= '0;
            r_last  <= '0;
        end else begin
            if (i_cmd.slot_next) begin
                r_slot <= r_slot + 1'b1;
            end
            if (i_cmd.alloc_step) begin
                r_blk <= r_blk + 1'b1;
            end
            if (w_claim) begin
                r_got  <= r_got + 1'b1;
                r_last <= r_blk;
                if (r_got == '0) begin
                    r_first <= r_blk;
                end
            end
            if (i_cmd.list_rd) begin
                r_idx <= r_idx + 1'b1;
            end
            if (r_lst_pend) begin
                r_last <= r_lst_q;
                if (r_lst_first) begin
                    r_first <= r_lst_q;
                end
            end
        end
    end

    // Block bitmap and free block count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_used <= '0;
            r_free_cnt   <= fba_pkg::FREE_W'(fba_pkg::BLOCKS);
        end else if (w_claim) begin
            r_block_used[r_blk] <= 1'b1;
            r_free_cnt          <= r_free_cnt - 1'b1;
        end else if (r_lst_pend &&
                     (fba_pkg::FREE_W'(r_lst_q) < fba_pkg::FREE_W'(fba_pkg::BLOCKS))) begin
            r_block_used[r_lst_q] <= 1'b0;
            r_free_cnt            <= r_free_cnt + 1'b1;
        end
    end

    // Directory valid bits and occupied slot count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_valid <= '0;
            r_used_slots  <= '0;
        end else if (i_cmd.commit_create) begin
            r_entry_valid[r_slot] <= 1'b1;
            r_used_slots          <= r_used_slots + 1'b1;
        end else if (i_cmd.commit_delete) begin
            r_entry_valid[r_slot] <= 1'b0;
            r_used_slots          <= r_used_slots - 1'b1;
        end
    end

    // Directory memory: name and block count per slot.
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit_create) begin
            r_dir_mem[r_slot] <= '{name: r_name, count: r_want};
        end
        if (i_cmd.name_rd) begin
            r_dir_q <= r_dir_mem[r_slot];
        end
    end

    // Block list memory: written while allocating, read while freeing.
    always_ff @(posedge i_clk) begin
        if (w_claim) begin
            r_list_mem[{r_slot, fba_pkg::BLK_W'(r_got)}] <= r_blk;
        end
        if (i_cmd.list_rd) begin
            r_lst_q     <= r_list_mem[{r_slot, fba_pkg::BLK_W'(r_idx)}];
            r_lst_first <= (r_idx == '0);
        end
    end

    // The list read data is registered, so this flag marks the cycle after a read is issued.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lst_pend <= 1'b0;
        end else begin
            r_lst_pend <= i_cmd.list_rd;
        end
    end

    // Result register; failures report zero slot and blocks.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.res_load) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            r_out_status <= i_cmd.res_status;
            r_out_slot   <= w_res_ok ? fba_pkg::OUT_W'(r_slot) : '0;
            r_out_first  <= fba_pkg::OUT_W'(r_first);
            r_out_last   <= fba_pkg::OUT_W'(r_last);
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_status      = r_out_status;
    assign o_slot        = r_out_slot;
    assign o_first_block = r_out_first;
    assign o_last_block  = r_out_last;

endmodule
`default_nettype wire

### rtl/fba_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fba_ctrl: allocator controller
// Sequences the slot search, the block allocation walk, the directory
// search and the block release walk, and issues one result per request.
// ----------------------------------------------------------------------------
module fba_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire fba_pkg::t_sts  i_sts,
    output fba_pkg::t_cmd       o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_SLOT  = 3'd2;
    localparam logic [2:0] S_ALLOC = 3'd3;
    localparam logic [2:0] S_DCHK  = 3'd4;
    localparam logic [2:0] S_DCMP  = 3'd5;
    localparam logic [2:0] S_DFREE = 3'd6;
    localparam logic [2:0] S_RESP  = 3'd7;

    logic [2:0]        r_state;
    logic [2:0]        n_state;
    fba_pkg::t_status  r_status;
    fba_pkg::t_status  n_status;

    assign o_in_ready = (r_state == S_IDLE);

    // Next state and command decode.
    always_comb begin
        n_state  = r_state;
        n_status = r_status;
        o_cmd    = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_sts.is_delete) begin
                    n_state = S_DCHK;
                end else if (i_sts.dir_full) begin
                    n_status = fba_pkg::ST_DIR_FULL;
                    n_state  = S_RESP;
                end else if (i_sts.no_space) begin
                    n_status = fba_pkg::ST_NO_SPACE;
                    n_state  = S_RESP;
                end else begin
                    n_state = S_SLOT;
                end
            end
            // Walk the slots until a free one turns up; one is known to exist.
            S_SLOT: begin
                if (i_sts.slot_free) begin
                    n_state = S_ALLOC;
                end else begin
                    o_cmd.slot_next = 1'b1;
                end
            end
            // Walk the bitmap, claiming free blocks until the request is met.
            S_ALLOC: begin
                if (i_sts.alloc_done) begin
                    o_cmd.commit_create = 1'b1;
                    n_status            = fba_pkg::ST_CREATED;
                    n_state             = S_RESP;
                end else begin
                    o_cmd.alloc_step = 1'b1;
                end
            end
            // Skip free slots; read the name of a valid one.
            S_DCHK: begin
                if (!i_sts.slot_free) begin
                    o_cmd.name_rd = 1'b1;
                    n_state       = S_DCMP;
                end else if (i_sts.slot_last) begin
                    n_status = fba_pkg::ST_NOT_FOUND;
                    n_state  = S_RESP;
                end else begin
                    o_cmd.slot_next = 1'b1;
                end
            end
            S_DCMP: begin
                if (i_sts.name_match) begin
                    n_state = S_DFREE;
                end else if (i_sts.slot_last) begin
                    n_status = fba_pkg::ST_NOT_FOUND;
                    n_state  = S_RESP;
                end else begin
                    o_cmd.slot_next = 1'b1;
                    n_state         = S_DCHK;
                end
            end
            // Stream the block list out and wait for the last read to land.
            S_DFREE: begin
                if (i_sts.list_more) begin
                    o_cmd.list_rd = 1'b1;
                end else if (!i_sts.list_pend) begin
                    o_cmd.commit_delete = 1'b1;
                    n_status            = fba_pkg::ST_DELETED;
                    n_state             = S_RESP;
                end
            end
            S_RESP: begin
                if (!i_sts.out_busy) begin
                    o_cmd.res_load   = 1'b1;
                    o_cmd.res_status = r_status;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_status <= fba_pkg::ST_CREATED;
        end else begin
            r_state  <= n_state;
            r_status <= n_status;
        end
    end

endmodule
`default_nettype wire

### rtl/file_block_allocator_unit.sv
`default_nettype none
// A create walks the slots to the first free one and the bitmap up to the last block claimed;
// a full directory or disk is reported without either walk.
// A delete walks the slots to the match, reading the name of each valid one, then frees
// its blocks; a name that is not found is reported after all slots are walked.
// One request at a time: the next is accepted once the result has loaded, and the load
// waits while an older word is held. Reset clears bitmap and valid bits at once.
// ----------------------------------------------------------------------------
// file_block_allocator_unit: first-fit block allocator with a file directory
// Creates files by claiming the lowest free slot and the lowest free blocks,
// and deletes files by name, releasing their blocks.
// ----------------------------------------------------------------------------
module file_block_allocator_unit (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    fba_req_if.sink     i_req,
    fba_rsp_if.source   o_rsp
);

    fba_pkg::t_cmd  w_cmd;
    fba_pkg::t_sts  w_sts;
    logic           w_in_ready;

    assign i_req.ready = w_in_ready;

    // Controller.
    fba_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // Datapath.
    fba_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_op          (i_req.op),
        .i_file_name   (i_req.file_name),
        .i_block_count (i_req.block_count),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_out_ready   (o_rsp.ready),
        .o_out_valid   (o_rsp.valid),
        .o_status      (o_rsp.status),
        .o_slot        (o_rsp.slot),
        .o_first_block (o_rsp.first_block),
        .o_last_block  (o_rsp.last_block)
    );

`ifndef SYNTH
    // Only one request is in flight at a time.
    a_single_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("request accepted while another was in flight");

    // A result is loaded only when the result register can take it.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.res_load |-> !w_sts.out_busy)
        else $error("result register overwritten before it was taken");

    // A result is produced only while a request is being worked on.
    a_result_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.res_load |-> !i_req.ready)
        else $error("result produced with no request in flight");

    // Failed requests report zero slot and block numbers.
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && (o_rsp.status == fba_pkg::ST_DIR_FULL ||
                         o_rsp.status == fba_pkg::ST_NO_SPACE ||
                         o_rsp.status == fba_pkg::ST_NOT_FOUND))
        |-> (o_rsp.slot == '0 && o_rsp.first_block == '0 && o_rsp.last_block == '0))
        else $error("failure result carries nonzero fields");
`endif

endmodule
`default_nettype wire
